// ===== hdl/thi_pkg.sv =====
// thi_pkg: shared widths, tolerance constants and side-band types
// for the triangle height interpolator; no dependencies
`timescale 1ns / 1ps

package thi_pkg;

  localparam int FW  = 32;   // field width, signed q16.16
  localparam int DW  = 33;   // vertex differences
  localparam int PW  = 66;   // cross product terms
  localparam int CW  = 68;   // sign-normalized cross products
  localparam int TW  = 80;   // tolerance compares
  localparam int HW  = 34;   // split point of the numerator products
  localparam int NW  = 101;  // interpolation numerator
  localparam int QW  = 34;   // quotient bits
  localparam int RW  = 102;  // divider remainder
  localparam int DNW = 69;   // divider denominator
  localparam int SW  = 36;   // height before saturation

  localparam logic [CW-1:0] DET_MIN = CW'(42950);
  localparam logic [TW-1:0] TOL_DEN = TW'(1000);
  localparam logic [TW-1:0] SUM_NUM = TW'(1001);

  typedef struct packed {
    logic          hit;
    logic          nneg;
    logic [FW-1:0] ay;
  } side_t;

endpackage

// ===== hdl/thi_if.sv =====
// thi_if: request channels of the triangle height interpolator
// depends on thi_pkg
`timescale 1ns / 1ps

interface thi_in_if;
  logic                     valid;
  logic                     ready;
  logic [thi_pkg::FW-1:0]   query_x;
  logic [thi_pkg::FW-1:0]   query_z;
  logic [thi_pkg::FW-1:0]   first_x;
  logic [thi_pkg::FW-1:0]   first_y;
  logic [thi_pkg::FW-1:0]   first_z;
  logic [thi_pkg::FW-1:0]   second_x;
  logic [thi_pkg::FW-1:0]   second_y;
  logic [thi_pkg::FW-1:0]   second_z;
  logic [thi_pkg::FW-1:0]   third_x;
  logic [thi_pkg::FW-1:0]   third_y;
  logic [thi_pkg::FW-1:0]   third_z;

  modport source (output valid, query_x, query_z, first_x, first_y, first_z,
                  second_x, second_y, second_z, third_x, third_y, third_z,
                  input ready);
  modport sink (input valid, query_x, query_z, first_x, first_y, first_z,
                second_x, second_y, second_z, third_x, third_y, third_z,
                output ready);
endinterface

interface thi_out_if;
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [thi_pkg::FW-1:0] height;

  modport source (output valid, hit, height, input ready);
  modport sink (input valid, hit, height, output ready);
endinterface

// ===== hdl/thi_div.sv =====
// thi_div: pipelined restoring divider, one quotient bit per stage
// depends on thi_pkg
`timescale 1ns / 1ps

module thi_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [thi_pkg::RW-1:0]    in_num,
  input  logic [thi_pkg::DNW-1:0]   in_den,
  input  thi_pkg::side_t            in_side,
  output logic                      out_valid,
  output logic [thi_pkg::QW-1:0]    out_quo,
  output thi_pkg::side_t            out_side
);

  localparam int QW  = thi_pkg::QW;
  localparam int RW  = thi_pkg::RW;
  localparam int DNW = thi_pkg::DNW;

  logic [QW-1:0]   v_r;
  logic [RW-1:0]   rem_r   [0:QW-2];
  logic [DNW-1:0]  den_r   [0:QW-2];
  logic [QW-1:0]   quo_r   [0:QW-1];
  thi_pkg::side_t  side_r  [0:QW-1];
  logic [RW-1:0]   rem_nxt [0:QW-2];
  logic [QW-1:0]   quo_nxt [0:QW-1];

  always_comb begin
    logic [RW-1:0] sh;
    logic          ge;
    // first stage works on the incoming operands
    sh               = RW'(in_den) << (QW - 1);
    ge               = in_num >= sh;
    rem_nxt[0]       = ge ? in_num - sh : in_num;
    quo_nxt[0]       = '0;
    quo_nxt[0][QW-1] = ge;
    for (int i = 1; i < QW - 1; i++) begin
      sh                 = RW'(den_r[i-1]) << (QW - 1 - i);
      ge                 = rem_r[i-1] >= sh;
      rem_nxt[i]         = ge ? rem_r[i-1] - sh : rem_r[i-1];
      quo_nxt[i]         = quo_r[i-1];
      quo_nxt[i][QW-1-i] = ge;
    end
    // last stage only needs the compare
    sh               = RW'(den_r[QW-2]);
    ge               = rem_r[QW-2] >= sh;
    quo_nxt[QW-1]    = quo_r[QW-2];
    quo_nxt[QW-1][0] = ge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
      for (int i = 0; i < QW - 1; i++) begin
        rem_r[i] <= rem_nxt[i];
      end
      for (int i = 1; i < QW - 1; i++) begin
        den_r[i] <= den_r[i-1];
      end
      for (int i = 0; i < QW; i++) begin
        quo_r[i] <= quo_nxt[i];
      end
      for (int i = 1; i < QW; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

// ===== hdl/triangle_height_interpolator_unit.sv =====
// triangle_height_interpolator_unit: barycentric height over one triangle
// depends on thi_pkg, thi_if and thi_div
//
//   channel   dir   payload
//   in_req    in    query_x/z, first/second/third x,y,z (signed q16.16)
//   out_rsp   out   hit, height (signed q16.16, zero on miss)
//
// one request enters per cycle while the output is not stalled; the path is eight arithmetic
// stages, one divider stage per quotient bit (34) and the output register
// the pipeline moves as one whenever the output register is empty or taken
// reset (synchronous, active low) clears all valid bits
// a stalled output freezes every stage; nothing is dropped or repeated
`timescale 1ns / 1ps

module triangle_height_interpolator_unit (
  input  logic           clk,
  input  logic           rst_n,
  thi_in_if.sink         in_req,
  thi_out_if.source      out_rsp
);

  localparam int FW = thi_pkg::FW;
  localparam int DW = thi_pkg::DW;
  localparam int PW = thi_pkg::PW;
  localparam int CW = thi_pkg::CW;
  localparam int TW = thi_pkg::TW;
  localparam int HW = thi_pkg::HW;
  localparam int NW = thi_pkg::NW;
  localparam int QW = thi_pkg::QW;
  localparam int RW = thi_pkg::RW;
  localparam int DNW = thi_pkg::DNW;
  localparam int SW = thi_pkg::SW;

  logic pipe_en;
  logic out_valid_r;
  logic out_hit_r;
  logic [FW-1:0] out_height_r;

  assign pipe_en      = !out_valid_r || out_rsp.ready;
  assign in_req.ready = pipe_en;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r <= in_req.valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r; v8_r <= v7_r;
    end
  end

  // stage 1: edge vectors
  logic signed [DW-1:0] abx1_r, abz1_r, acx1_r, acz1_r, apx1_r, apz1_r;
  logic signed [DW-1:0] dby1_r, dcy1_r;
  logic [FW-1:0] ay1_r;

  function automatic logic signed [DW-1:0] dif(input logic [FW-1:0] a,
                                               input logic [FW-1:0] b);
    return $signed({a[FW-1], a}) - $signed({b[FW-1], b});
  endfunction

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      abx1_r <= dif(in_req.second_x, in_req.first_x);
      abz1_r <= dif(in_req.second_z, in_req.first_z);
      acx1_r <= dif(in_req.third_x, in_req.first_x);
      acz1_r <= dif(in_req.third_z, in_req.first_z);
      apx1_r <= dif(in_req.query_x, in_req.first_x);
      apz1_r <= dif(in_req.query_z, in_req.first_z);
      dby1_r <= dif(in_req.second_y, in_req.first_y);
      dcy1_r <= dif(in_req.third_y, in_req.first_y);
      ay1_r  <= in_req.first_y;
    end
  end

  // stage 2: cross product terms
  logic signed [PW-1:0] pd0_r, pd1_r, pu0_r, pu1_r, pv0_r, pv1_r;
  logic signed [DW-1:0] dby2_r, dcy2_r;
  logic [FW-1:0] ay2_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pd0_r  <= abx1_r * acz1_r;
      pd1_r  <= acx1_r * abz1_r;
      pu0_r  <= apx1_r * acz1_r;
      pu1_r  <= acx1_r * apz1_r;
      pv0_r  <= abx1_r * apz1_r;
      pv1_r  <= apx1_r * abz1_r;
      dby2_r <= dby1_r;
      dcy2_r <= dcy1_r;
      ay2_r  <= ay1_r;
    end
  end

  // stage 3: det, nu, nv
  logic signed [CW-1:0] det3_r, nu3_r, nv3_r;
  logic signed [DW-1:0] dby3_r, dcy3_r;
  logic [FW-1:0] ay3_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      det3_r <= CW'(pd0_r) - CW'(pd1_r);
      nu3_r  <= CW'(pu0_r) - CW'(pu1_r);
      nv3_r  <= CW'(pv0_r) - CW'(pv1_r);
      dby3_r <= dby2_r;
      dcy3_r <= dcy2_r;
      ay3_r  <= ay2_r;
    end
  end

  // stage 4: make det positive
  logic signed [CW-1:0] det4_r, nu4_r, nv4_r;
  logic signed [DW-1:0] dby4_r, dcy4_r;
  logic [FW-1:0] ay4_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      det4_r <= det3_r[CW-1] ? -det3_r : det3_r;
      nu4_r  <= det3_r[CW-1] ? -nu3_r : nu3_r;
      nv4_r  <= det3_r[CW-1] ? -nv3_r : nv3_r;
      dby4_r <= dby3_r;
      dcy4_r <= dcy3_r;
      ay4_r  <= ay3_r;
    end
  end

  // stage 5: tolerance band and numerator partial products
  logic signed [TW-1:0] det_w, nu_w, nv_w;
  logic hit5;
  logic signed [HW:0]   nul_s, nvl_s;
  logic hit5_r;
  logic signed [CW-1:0] det5_r;
  logic signed [HW+DW:0]   ul5_r, vl5_r;
  logic signed [CW-HW+DW-1:0] uh5_r, vh5_r;
  logic [FW-1:0] ay5_r;

  always_comb begin
    det_w = TW'(det4_r);
    nu_w  = TW'(nu4_r);
    nv_w  = TW'(nv4_r);
    hit5  = (det4_r >= $signed(thi_pkg::DET_MIN))
         && !((nu_w * $signed(thi_pkg::TOL_DEN)) < -det_w)
         && !((nv_w * $signed(thi_pkg::TOL_DEN)) < -det_w)
         && !((det_w * $signed(thi_pkg::SUM_NUM))
              < ((nu_w + nv_w) * $signed(thi_pkg::TOL_DEN)));
    nul_s = $signed({1'b0, nu4_r[HW-1:0]});
    nvl_s = $signed({1'b0, nv4_r[HW-1:0]});
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      hit5_r <= hit5;
      det5_r <= det4_r;
      ul5_r  <= dby4_r * nul_s;
      vl5_r  <= dcy4_r * nvl_s;
      uh5_r  <= dby4_r * $signed(nu4_r[CW-1:HW]);
      vh5_r  <= dcy4_r * $signed(nv4_r[CW-1:HW]);
      ay5_r  <= ay4_r;
    end
  end

  // stage 6: recombine the partial products
  logic signed [NW-1:0] pu6_r, pv6_r;
  logic hit6_r;
  logic signed [CW-1:0] det6_r;
  logic [FW-1:0] ay6_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pu6_r  <= (NW'(uh5_r) <<< HW) + NW'(ul5_r);
      pv6_r  <= (NW'(vh5_r) <<< HW) + NW'(vl5_r);
      hit6_r <= hit5_r;
      det6_r <= det5_r;
      ay6_r  <= ay5_r;
    end
  end

  // stage 7: numerator magnitude and sign
  logic signed [NW-1:0] num7;
  logic [NW-1:0] mag7_r;
  logic nneg7_r, hit7_r;
  logic signed [CW-1:0] det7_r;
  logic [FW-1:0] ay7_r;

  assign num7 = pu6_r + pv6_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      mag7_r  <= num7[NW-1] ? NW'(-num7) : NW'(num7);
      nneg7_r <= num7[NW-1];
      hit7_r  <= hit6_r;
      det7_r  <= det6_r;
      ay7_r   <= ay6_r;
    end
  end

  // stage 8: rounded division operands
  logic [RW-1:0]  n8_r;
  logic [DNW-1:0] d8_r;
  thi_pkg::side_t side8_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      n8_r         <= (RW'(mag7_r) << 1) + RW'(unsigned'(det7_r));
      d8_r         <= DNW'(unsigned'(det7_r)) << 1;
      side8_r.hit  <= hit7_r;
      side8_r.nneg <= nneg7_r;
      side8_r.ay   <= ay7_r;
    end
  end

  logic           div_valid;
  logic [QW-1:0]  div_quo;
  thi_pkg::side_t div_side;

  thi_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (v8_r),
    .in_num    (n8_r),
    .in_den    (d8_r),
    .in_side   (side8_r),
    .out_valid (div_valid),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // final: add to first vertex height and saturate
  logic signed [SW-1:0] qs, hs;
  logic [FW-1:0] sat;

  always_comb begin
    qs = $signed(SW'(div_quo));
    hs = $signed(SW'($signed(div_side.ay))) + (div_side.nneg ? -qs : qs);
    if (hs > $signed(SW'($signed({1'b0, {(FW-1){1'b1}}})))) begin
      sat = {1'b0, {(FW-1){1'b1}}};
    end else if (hs < $signed(SW'($signed({1'b1, {(FW-1){1'b0}}})))) begin
      sat = {1'b1, {(FW-1){1'b0}}};
    end else begin
      sat = hs[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_hit_r    <= div_side.hit;
      out_height_r <= div_side.hit ? sat : '0;
    end
  end

  assign out_rsp.valid  = out_valid_r;
  assign out_rsp.hit    = out_hit_r;
  assign out_rsp.height = out_height_r;

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(v1_r) && $stable(v8_r) && $stable(out_height_r))
    else $error("pipeline moved during stall");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> out_height_r == '0)
    else $error("miss with nonzero height");

  a_hit_nondegen: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r && hit6_r |-> det6_r >= $signed(thi_pkg::DET_MIN))
    else $error("hit on degenerate triangle");

endmodule

// ===== tb/sv/testbench.sv =====
// testbench: random and directed checks of triangle_height_interpolator_unit
// depends on thi_pkg, thi_if and the unit; exact wide-integer height predictor
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [thi_pkg::FW-1:0] qx, qz, ax, ay, az, bx, by, bz, cx, cy, cz;
  } tri_query_t;

  typedef struct packed {
    logic                   hit;
    logic [thi_pkg::FW-1:0] height;
  } height_result_t;

  logic clk;
  logic rst_n;

  thi_in_if  in_req();
  thi_out_if out_rsp();

  triangle_height_interpolator_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  tri_query_t     pending_queries[$];
  height_result_t expected_heights[$];
  tri_query_t     cur_query;
  int             send_gap;
  int             recv_gap;
  int             hold_left;
  int             results_seen;
  int             errors;
  bit             pressed;
  bit             calm;

  function automatic height_result_t interpolate_height(tri_query_t t);
    logic signed [127:0] px, pz, ax, ay, az, bx, by, bz, cx, cy, cz;
    logic signed [127:0] abx, abz, acx, acz, apx, apz, det, nu, nv;
    logic signed [127:0] num, mag, q, h;
    logic                nneg;
    height_result_t      r;
    px = $signed(t.qx); pz = $signed(t.qz);
    ax = $signed(t.ax); ay = $signed(t.ay); az = $signed(t.az);
    bx = $signed(t.bx); by = $signed(t.by); bz = $signed(t.bz);
    cx = $signed(t.cx); cy = $signed(t.cy); cz = $signed(t.cz);
    abx = bx - ax; abz = bz - az;
    acx = cx - ax; acz = cz - az;
    apx = px - ax; apz = pz - az;
    det = abx * acz - acx * abz;
    nu  = apx * acz - acx * apz;
    nv  = abx * apz - apx * abz;
    r = '0;
    if (det < 0) begin
      det = -det; nu = -nu; nv = -nv;
    end
    if (det < 42950) return r;
    if (nu * 1000 < -det) return r;
    if (nv * 1000 < -det) return r;
    if (det * 1001 < (nu + nv) * 1000) return r;
    num  = (by - ay) * nu + (cy - ay) * nv;
    nneg = num < 0;
    mag  = nneg ? -num : num;
    q    = (2 * mag + det) / (2 * det);
    h    = q & 128'hFFFF_FFFF_FFFF;
    h    = nneg ? ay - h : ay + h;
    if (h > 128'sd2147483647) h = 128'sd2147483647;
    if (h < -128'sd2147483648) h = -128'sd2147483648;
    r.hit    = 1'b1;
    r.height = h[thi_pkg::FW-1:0];
    return r;
  endfunction

  task automatic add_query(int px, int pz, int ax, int ay, int az,
                           int bx, int by, int bz, int cx, int cy, int cz);
    tri_query_t t;
    t = '{px, pz, ax, ay, az, bx, by, bz, cx, cy, cz};
    pending_queries = {pending_queries, t};
  endtask

  // triangle of random size and place, point mostly near or inside it
  task automatic add_random_triangle();
    longint base_x, base_z, bx, bz, cx, cz, w1, w2, px, pz, span;
    int     shift;
    shift  = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 31) : $urandom_range(4, 22);
    span   = longint'(1) << shift;
    base_x = longint'($signed($urandom())) >>> $urandom_range(0, 8);
    base_z = longint'($signed($urandom())) >>> $urandom_range(0, 8);
    bx = base_x + $urandom_range(0, 32'hFFFF_FFFF) % span - span / 2;
    bz = base_z + $urandom_range(0, 32'hFFFF_FFFF) % span - span / 2;
    cx = base_x + $urandom_range(0, 32'hFFFF_FFFF) % span - span / 2;
    cz = base_z + $urandom_range(0, 32'hFFFF_FFFF) % span - span / 2;
    w1 = longint'($urandom_range(0, 1100)) - 40;
    w2 = longint'($urandom_range(0, 1100)) - 40;
    if ($urandom_range(0, 3) != 0 && w1 + w2 > 1024) begin
      w1 = 1024 - w1; w2 = 1024 - w2;
    end
    px = base_x + ((bx - base_x) * w1 + (cx - base_x) * w2) / 1024;
    pz = base_z + ((bz - base_z) * w1 + (cz - base_z) * w2) / 1024;
    if ($urandom_range(0, 7) == 0) px = px + $urandom_range(0, 200) - 100;
    add_query(int'(px), int'(pz), int'(base_x), $urandom(), int'(base_z),
              int'(bx), $urandom(), int'(bz), int'(cx), $urandom(), int'(cz));
  endtask

  task automatic add_noise_query();
    tri_query_t t;
    t = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
         $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    pending_queries = {pending_queries, t};
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 400000);
    $display("Some tests failed");
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_req.valid && in_req.ready)
        expected_heights = {expected_heights, interpolate_height(cur_query)};
      if (in_req.valid && !in_req.ready) begin
        // hold the current request
      end else if (send_gap > 0) begin
        send_gap--;
        in_req.valid <= 1'b0;
      end else if (pending_queries.size() == 0) begin
        in_req.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        send_gap = $urandom_range(1, 15) - 1;
        in_req.valid <= 1'b0;
      end else begin
        cur_query = pending_queries.pop_front();
        in_req.query_x  <= cur_query.qx;
        in_req.query_z  <= cur_query.qz;
        in_req.first_x  <= cur_query.ax;
        in_req.first_y  <= cur_query.ay;
        in_req.first_z  <= cur_query.az;
        in_req.second_x <= cur_query.bx;
        in_req.second_y <= cur_query.by;
        in_req.second_z <= cur_query.bz;
        in_req.third_x  <= cur_query.cx;
        in_req.third_y  <= cur_query.cy;
        in_req.third_z  <= cur_query.cz;
        in_req.valid    <= 1'b1;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) begin
        results_seen++;
        if (expected_heights.size() == 0) begin
          $error("unexpected result hit=%0b height=%h", out_rsp.hit, out_rsp.height);
          errors++;
        end else begin
          height_result_t e;
          e = expected_heights.pop_front();
          if (out_rsp.hit !== e.hit) begin
            $error("hit expected %0b actual %0b", e.hit, out_rsp.hit);
            errors++;
          end
          if (out_rsp.height !== e.height) begin
            $error("height expected %h actual %h", e.height, out_rsp.height);
            errors++;
          end
        end
      end
      if (!pressed && results_seen >= 300) begin
        pressed = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_rsp.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_rsp.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        recv_gap = $urandom_range(1, 15) - 1;
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    int wait_cycles;
    errors = 0;
    results_seen = 0;
    pressed = 1'b0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    {in_req.query_x, in_req.query_z, in_req.first_x, in_req.first_y, in_req.first_z,
     in_req.second_x, in_req.second_y, in_req.second_z, in_req.third_x, in_req.third_y,
     in_req.third_z} = '0;
    out_rsp.ready = 1'b0;

    // unit triangle, centroid, vertices, edges, tolerance band
    add_query(21845, 21845, 0, 0, 0, 65536, 65536, 0, 0, 131072, 65536);
    add_query(0, 0, 0, 100, 0, 65536, 200, 0, 0, 300, 65536);
    add_query(65536, 0, 0, 100, 0, 65536, 200, 0, 0, 300, 65536);
    add_query(0, 65536, 0, 100, 0, 65536, 200, 0, 0, 300, 65536);
    add_query(32768, 32768, 0, -5, 0, 65536, 7, 0, 0, 9, 65536);
    add_query(-131, 100, 0, 0, 0, 65536, 65536, 0, 0, 65536, 65536);
    add_query(-33, 100, 0, 0, 0, 65536, 65536, 0, 0, 65536, 65536);
    add_query(100, -131, 0, 0, 0, 65536, 65536, 0, 0, 65536, 65536);
    add_query(32797, 32797, 0, 0, 0, 65536, 65536, 0, 0, -65536, 65536);
    add_query(32835, 32835, 0, 0, 0, 65536, 65536, 0, 0, -65536, 65536);
    // clockwise order
    add_query(21845, 21845, 0, 0, 0, 0, 131072, 65536, 65536, 65536, 0);
    // degenerate: collinear, all zero, just below and at the determinant floor
    add_query(10, 10, 0, 0, 0, 65536, 5, 65536, 131072, 7, 131072);
    add_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_query(0, 0, 0, 3, 0, 1, 4, 0, 0, 5, 42949);
    add_query(0, 0, 0, 3, 0, 1, 4, 0, 0, 5, 42950);
    // saturation both ways
    add_query(65595, 0, 0, 32'h7FFF0000, 0, 65536, 32'h7FFFFFFF, 0, 0, 32'h7FFF0000, 65536);
    add_query(65595, 0, 0, 32'h80010000, 0, 65536, 32'h80000000, 0, 0, 32'h80010000, 65536);
    add_query(65536, 0, 0, 32'h80000000, 0, 65536, 32'h7FFFFFFF, 0, 0, 0, 65536);
    // field extremes
    add_query(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
              32'h7FFFFFFF);
    add_query(0, 0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
    add_query(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
    add_query(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'h7FFFFFFF);
    for (int i = 0; i < 1230; i++) begin
      if ($urandom_range(0, 4) == 0) add_noise_query();
      else add_random_triangle();
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_queries.size() >= 150) @(posedge clk);
    calm = 1'b1;
    while (pending_queries.size() != 0 || in_req.valid) @(posedge clk);
    while (expected_heights.size() != 0) @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < 60) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (expected_heights.size() != 0) begin
      $error("%0d results never arrived", expected_heights.size());
      errors++;
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
